FILE: design/calendar_date_advance_assert.svh
// Assertion macros used by the date block's datapath.
`ifndef CALENDAR_DATE_ADVANCE_ASSERT_SVH
`define CALENDAR_DATE_ADVANCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Types, codes and calendar helpers shared by the date advance block.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

    localparam int DAY_W        = 5;
    localparam int MONTH_W      = 4;
    localparam int YEAR_FIELD_W = 16;
    localparam int ADV_FIELD_W  = 16;
    localparam int Y400_W       = 9;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;

    localparam logic [Y400_W-1:0] CYCLE_400     = 9'd400 - 9'd0;
    localparam logic [Y400_W-1:0] CYCLE_LAST    = 9'd399;
    localparam logic [Y400_W-1:0] CENTURY_ONE   = 9'd100;
    localparam logic [Y400_W-1:0] CENTURY_TWO   = 9'd200;
    localparam logic [Y400_W-1:0] CENTURY_THREE = 9'd300;

    // A loaded year is split as 16 * hi + lo, so its remainder modulo 400 is
    // 16 * (hi mod 25) + lo. The quotient hi / 25 comes from a reciprocal
    // multiply that is exact for every 12-bit hi.
    localparam int               YLO_W       = 4;
    localparam int               YHI_W       = YEAR_FIELD_W - YLO_W;
    localparam int               DIV25_SHIFT = 16;
    localparam logic [YHI_W-1:0] DIV25_MUL   = 12'd2622;
    localparam logic [4:0]       DIV25       = 5'd25;

    typedef struct packed {
        logic                    func;
        logic [DAY_W-1:0]        load_day;
        logic [MONTH_W-1:0]      load_month;
        logic [YEAR_FIELD_W-1:0] load_year;
        logic [ADV_FIELD_W-1:0]  advance_days;
    } t_in;

    typedef struct packed {
        logic [DAY_W-1:0]        cur_day;
        logic [MONTH_W-1:0]      cur_month;
        logic [YEAR_FIELD_W-1:0] cur_year;
        logic                    bad_date;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_ADV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load_start;
        logic adv_start;
        logic mod_step;
        logic adv_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic mod_last;
        logic carry;
        logic out_free;
    } t_stat;

    // Leap test from the year's remainder modulo 400.
    function automatic logic is_leap(input logic [Y400_W-1:0] y400);
        logic four;
        logic century;
        four    = (y400[1:0] == 2'b00);
        century = (y400 == CENTURY_ONE) || (y400 == CENTURY_TWO) ||
                  (y400 == CENTURY_THREE);
        return four && !century;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: design/cda_ctrl.sv
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer for the date block: load remainder pass, month stepping, result.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_ctrl
    import cda_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_func,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_func == FUNC_LOAD) begin
                        o_cmd.load_start = 1'b1;
                        n_state          = S_MOD;
                    end else begin
                        o_cmd.adv_start = 1'b1;
                        // A badly formed date is returned unchanged.
                        n_state = i_stat.bad ? S_FINISH : S_ADV;
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_FINISH;
                end
            end
            S_ADV: begin
                o_cmd.adv_step = 1'b1;
                if (!i_stat.carry) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/cda_dpath.sv
// ----------------------------------------------------------------------------
// cda_dpath
// Date registers, remainder-by-400 unit, month stepper and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_dpath
    import cda_pkg::*;
#(
    parameter int YEAR_BITS    = 16,
    parameter int ADVANCE_BITS = 16
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  t_in   i_in_data,
    input  t_cmd  i_cmd,
    input  wire   i_out_ready,
    output t_stat o_stat,
    output logic  o_out_valid,
    output t_out  o_out_data
);

    localparam int LOAD_BITS = (YEAR_BITS < YEAR_FIELD_W) ? YEAR_BITS : YEAR_FIELD_W;
    localparam int EFF_BITS  = (ADVANCE_BITS < ADV_FIELD_W) ? ADVANCE_BITS : ADV_FIELD_W;
    localparam int ACC_W     = EFF_BITS + 1;
    localparam int PROD_W    = 2 * YHI_W;
    localparam int QUO_W     = PROD_W - DIV25_SHIFT;

    logic [DAY_W-1:0]     r_day;
    logic [MONTH_W-1:0]   r_month;
    logic [YEAR_BITS-1:0] r_year;
    logic                 r_bad;
    logic [Y400_W-1:0]    r_y400;
    logic [ACC_W-1:0]     r_acc;
    logic [QUO_W-1:0]     r_quo;
    logic                 r_phase;
    logic                 r_out_valid;
    t_out                 r_out;

    logic [DAY_W-1:0]        len;
    logic                    carry;
    logic [YEAR_FIELD_W-1:0] year_ext;
    logic [YHI_W-1:0]        year_hi;
    logic [PROD_W-1:0]       quo_prod;
    logic [YHI_W-1:0]        rem_hi;
    logic [Y400_W-1:0]       y400_load;
    logic                    load_bad;
    logic                    adv_legal;
    logic                    rem_done;
    logic                    acc_step;
    logic                    out_good;

    assign len   = month_len(r_month, is_leap(r_y400));
    assign carry = (r_acc > ACC_W'(len));

    // The freshly loaded year sits in r_year while the remainder is built: the
    // first step takes the quotient by 25 into r_quo, the second the remainder.
    assign year_ext  = YEAR_FIELD_W'(r_year[LOAD_BITS-1:0]);
    assign year_hi   = year_ext[YEAR_FIELD_W-1:YLO_W];
    assign quo_prod  = PROD_W'(year_hi) * PROD_W'(DIV25_MUL);
    assign rem_hi    = year_hi - YHI_W'(r_quo) * YHI_W'(DIV25);
    assign y400_load = {rem_hi[Y400_W-YLO_W-1:0], year_ext[YLO_W-1:0]};

    assign load_bad = (i_in_data.load_day == '0) || (i_in_data.load_month == '0) ||
                      (i_in_data.load_month > MONTH_DEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= DAY_FIRST;
            r_month <= MONTH_JAN;
            r_year  <= '0;
            r_bad   <= 1'b0;
            r_y400  <= '0;
        end else begin
            if (i_cmd.load_start) begin
                r_day   <= i_in_data.load_day;
                r_month <= i_in_data.load_month;
                r_year  <= YEAR_BITS'(i_in_data.load_year);
                r_bad   <= load_bad;
                r_y400  <= '0;
            end else if (i_cmd.mod_step) begin
                if (r_phase) begin
                    r_y400 <= y400_load;
                end
            end else if (i_cmd.adv_step) begin
                if (carry) begin
                    if (r_month == MONTH_DEC) begin
                        r_month <= MONTH_JAN;
                        r_year  <= r_year + 1'b1;
                        if (r_year == '1) begin
                            r_y400 <= '0;
                        end else if (r_y400 == CYCLE_LAST) begin
                            r_y400 <= '0;
                        end else begin
                            r_y400 <= r_y400 + 1'b1;
                        end
                    end else begin
                        r_month <= r_month + 1'b1;
                    end
                end else begin
                    r_day <= r_acc[DAY_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_phase <= 1'b0;
        end else if (i_cmd.mod_step) begin
            r_phase <= !r_phase;
            if (!r_phase) begin
                r_quo <= quo_prod[PROD_W-1:DIV25_SHIFT];
            end
        end
        if (i_cmd.adv_start) begin
            r_acc <= ACC_W'(r_day) + ACC_W'(i_in_data.advance_days[EFF_BITS-1:0]);
        end else if (i_cmd.adv_step && carry) begin
            r_acc <= r_acc - ACC_W'(len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.cur_day   <= r_day;
            r_out.cur_month <= r_month;
            r_out.cur_year  <= YEAR_FIELD_W'(r_year);
            r_out.bad_date  <= r_bad;
        end
    end

    assign o_stat.bad      = r_bad;
    assign o_stat.mod_last = r_phase;
    assign o_stat.carry    = carry;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    assign adv_legal = (r_month != '0) && (r_month <= MONTH_DEC) && !r_bad;
    assign rem_done  = i_cmd.mod_step && r_phase;
    assign acc_step  = i_cmd.adv_step && carry;
    assign out_good  = i_cmd.out_load && !r_bad;

`include "calendar_date_advance_assert.svh"

    `CDA_ASSERT_SAME(a_adv_month_legal, i_clk, i_rst_n, i_cmd.adv_step, adv_legal, "bad month")
    `CDA_ASSERT_NEXT(a_rem_below_400, i_clk, i_rst_n, rem_done, r_y400 < CYCLE_400, "bad remainder")
    `CDA_ASSERT_NEXT(a_acc_shrinks, i_clk, i_rst_n, acc_step, r_acc < $past(r_acc), "count grew")
    `CDA_ASSERT_SAME(a_day_nonzero, i_clk, i_rst_n, out_good, r_day != '0, "well formed date has day zero")

endmodule

`default_nettype wire

FILE: design/calendar_date_advance.sv
// Gregorian date register with load and advance.
// Input channel (i_in_valid / o_in_ready, payload i_in_data): one beat is a
// load (func 0) or an advance by a day count (func 1). Output channel
// (o_out_valid / i_out_ready, payload o_out_data): one beat per input beat,
// holding the date and the bad flag after that item, in order.
// A load's result waits for the year's remainder modulo 400, which drives the
// leap test: a reciprocal multiply registered in r_quo, then a multiply-subtract
// into r_y400.
// An advance's result waits while the month stepper subtracts one month length
// per cycle, once for each month carried; a full 16-bit count reaches about
// 2150 months. An advance on a bad date skips the month stepper and goes
// straight to the result.
// One item is worked at a time; the next beat is taken the cycle after the
// result is loaded, even while the previous result still waits in the
// output register.
// A stalled receiver holds the finished result, and the next item then waits
// with its own result until the output register frees.
// After reset the date is day 1, month 1, year 0, not bad, and no result
// is pending.
// ----------------------------------------------------------------------------
// calendar_date_advance
// Top level: sequencer plus date datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_advance
    import cda_pkg::*;
#(
    parameter int YEAR_BITS    = 16,
    parameter int ADVANCE_BITS = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  wire  i_out_ready,
    output t_out o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    cda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    cda_dpath #(
        .YEAR_BITS    (YEAR_BITS),
        .ADVANCE_BITS (ADVANCE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
